@@ rtl/tcc_pkg.sv @@
`default_nettype none
package tcc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int XW         = SAMPLE_W + 1;        // sample minus offset
  localparam int ANGLE_FRAC = 7;
  localparam int ROLL_W     = 15;
  localparam int HEAD_W     = 16;
  localparam int PRESHIFT   = 30 - SAMPLE_W;
  localparam int ROOT_BITS  = 31;
  localparam int ANG_W      = 26;                  // Q16 degrees
  localparam int VW         = 32;                  // atan2 operands of roll, pitch, raw heading
  localparam int CS_W       = 33;                  // Q30 sine and cosine
  localparam int HW         = 53;                  // tilt heading operands
  localparam int RND_SHIFT  = 16 - ANGLE_FRAC;
  localparam int TABLE_LEN  = 24;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int IDX_W      = 3;

  localparam logic signed [ANG_W-1:0] DEG90     = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360 << ANGLE_FRAC);
  localparam logic signed [ANG_W-1:0] DEG_HALF  = ANG_W'(1 << (RND_SHIFT - 1));

  // atan(2^-i) in Q16 degrees
  localparam logic signed [ANG_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
    26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
  };

  typedef enum logic [IDX_W-1:0] {
    REG_ACCEL_OFS_X = 3'd0,
    REG_ACCEL_OFS_Y = 3'd1,
    REG_ACCEL_OFS_Z = 3'd2,
    REG_MAG_OFS_X   = 3'd3,
    REG_MAG_OFS_Y   = 3'd4,
    REG_MAG_OFS_Z   = 3'd5
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [XW-1:0] ax;
    logic signed [XW-1:0] ay;
    logic signed [XW-1:0] az;
    logic signed [XW-1:0] mx;
    logic signed [XW-1:0] my;
    logic signed [XW-1:0] mz;
  } axis_t;

  function automatic logic [63:0] cordic_gain(input int n);
    logic [63:0] g;
    g = 64'd1 << 60;
    for (int i = 0; i < n; i++) g = g + (g >> (2 * i));
    return g;
  endfunction

  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = v;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] clamp90(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    r = a;
    if (a > DEG90) r = DEG90;
    else if (a < -DEG90) r = -DEG90;
    return r;
  endfunction

  // round half away from zero, Q16 degrees to output units
  function automatic logic signed [ANG_W-1:0] round_deg(input logic signed [ANG_W-1:0] z);
    logic signed [ANG_W-1:0] m;
    logic signed [ANG_W-1:0] q;
    m = (z < 0) ? -z : z;
    q = (m + DEG_HALF) >>> RND_SHIFT;
    return (z < 0) ? -q : q;
  endfunction

  function automatic logic [HEAD_W-1:0] wrap_heading(input logic signed [ANG_W-1:0] z);
    logic signed [ANG_W-1:0] h;
    h = round_deg(z);
    if (h < 0) h = h + FULL_TURN;
    else if (h >= FULL_TURN) h = h - FULL_TURN;
    return h[HEAD_W-1:0];
  endfunction

  function automatic logic signed [CS_W-1:0] round_q30(input logic signed [2*CS_W-1:0] p);
    logic signed [2*CS_W-1:0] m;
    logic signed [2*CS_W-1:0] q;
    logic signed [2*CS_W-1:0] r;
    m = (p < 0) ? -p : p;
    q = (m + (2*CS_W)'(64'd1 << 29)) >>> 30;
    r = (p < 0) ? -q : q;
    return r[CS_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/tcc_in_if.sv @@
`default_nettype none
interface tcc_in_if;
  import tcc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;
  sample_t mag_x;
  sample_t mag_y;
  sample_t mag_z;
  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/tcc_out_if.sv @@
`default_nettype none
interface tcc_out_if;
  import tcc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ROLL_W-1:0] roll_angle;
  logic signed [ROLL_W-1:0] pitch_angle;
  logic [HEAD_W-1:0]        heading_raw;
  logic [HEAD_W-1:0]        heading_tilt;
  modport source (output valid, roll_angle, pitch_angle, heading_raw, heading_tilt,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, heading_raw, heading_tilt,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/tcc_dly.sv @@
`default_nettype none
module tcc_dly #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < D; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[D-1];
endmodule
`default_nettype wire

@@ rtl/tcc_isqrt.sv @@
`default_nettype none
module tcc_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [2*tcc_pkg::XW-1:0]         sum,
  output logic [tcc_pkg::ROOT_BITS-1:0]    root
);
  import tcc_pkg::*;
  localparam int NW = 2 * ROOT_BITS;

  logic [NW-1:0] n_q [ROOT_BITS];
  logic [NW-1:0] r_q [ROOT_BITS];

  // one result bit per stage, trial bit 4^k from the top down
  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (ROOT_BITS - 1 - j));
    logic [NW-1:0] n_in;
    logic [NW-1:0] r_in;
    logic [NW:0]   trial;
    if (j == 0) begin : g_first
      assign n_in = {sum, {(2*PRESHIFT){1'b0}}};
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[j-1];
      assign r_in = r_q[j-1];
    end
    assign trial = {1'b0, r_in} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, n_in} >= trial) begin
          n_q[j] <= n_in - trial[NW-1:0];
          r_q[j] <= (r_in >> 1) + BIT;
        end else begin
          n_q[j] <= n_in;
          r_q[j] <= r_in >> 1;
        end
      end
    end
  end

  assign root = r_q[ROOT_BITS-1][ROOT_BITS-1:0];
endmodule
`default_nettype wire

@@ rtl/tcc_vec.sv @@
`default_nettype none
module tcc_vec #(
  parameter int IW = 32,
  parameter int N  = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [IW-1:0]              y_in,
  input  logic signed [IW-1:0]              x_in,
  output logic signed [tcc_pkg::ANG_W-1:0]  angle
);
  import tcc_pkg::*;
  localparam int CW = IW + 3;

  logic signed [CW-1:0]    xs [N+1];
  logic signed [CW-1:0]    ys [N+1];
  logic signed [ANG_W-1:0] zs [N+1];
  logic                    zf [N+1];
  logic signed [CW-1:0]    xe;
  logic signed [CW-1:0]    ye;

  assign xe = CW'(x_in);
  assign ye = CW'(y_in);

  // fold the left half plane by a quarter turn
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (xe < 0) begin
        if (ye >= 0) begin
          xs[0] <= ye;
          ys[0] <= -xe;
          zs[0] <= DEG90;
        end else begin
          xs[0] <= -ye;
          ys[0] <= xe;
          zs[0] <= -DEG90;
        end
      end else begin
        xs[0] <= xe;
        ys[0] <= ye;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_Q16[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_Q16[i];
        end
      end
    end
  end

  assign angle = zf[N] ? '0 : zs[N];
endmodule
`default_nettype wire

@@ rtl/tcc_rot.sv @@
`default_nettype none
module tcc_rot #(
  parameter int N = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [tcc_pkg::ANG_W-1:0] ang,
  output logic signed [tcc_pkg::CS_W-1:0]  cos_q30,
  output logic signed [tcc_pkg::CS_W-1:0]  sin_q30
);
  import tcc_pkg::*;
  localparam logic [63:0] GAIN  = cordic_gain(N);
  localparam logic [63:0] GROOT = isqrt_const(GAIN);
  localparam logic [63:0] K_Q30 = ((64'd1 << 60) + (GROOT >> 1)) / GROOT;

  logic signed [CS_W-1:0]  xs [N];
  logic signed [CS_W-1:0]  ys [N];
  logic signed [ANG_W-1:0] zs [N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CS_W-1:0]  x_in;
    logic signed [CS_W-1:0]  y_in;
    logic signed [ANG_W-1:0] z_in;
    if (i == 0) begin : g_first
      assign x_in = signed'(K_Q30[CS_W-1:0]);
      assign y_in = '0;
      assign z_in = ang;
    end else begin : g_next
      assign x_in = xs[i-1];
      assign y_in = ys[i-1];
      assign z_in = zs[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_in >= 0) begin
          xs[i] <= x_in - (y_in >>> i);
          ys[i] <= y_in + (x_in >>> i);
          zs[i] <= z_in - ATAN_Q16[i];
        end else begin
          xs[i] <= x_in + (y_in >>> i);
          ys[i] <= y_in - (x_in >>> i);
          zs[i] <= z_in + ATAN_Q16[i];
        end
      end
    end
  end

  assign cos_q30 = xs[N-1];
  assign sin_q30 = ys[N-1];
endmodule
`default_nettype wire

@@ rtl/tcc_front.sv @@
`default_nettype none
module tcc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tcc_pkg::SAMPLE_W-1:0]  cfg_data,
  tcc_in_if.sink                        sensor,
  output logic                          q_valid,
  input  logic                          q_pop,
  output tcc_pkg::axis_t                q_word
);
  import tcc_pkg::*;

  sample_t ofs_ax, ofs_ay, ofs_az, ofs_mx, ofs_my, ofs_mz;
  logic    fv;
  axis_t   fword;
  axis_t   qmem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic    full, push, take;

  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_ax <= '0;
      ofs_ay <= '0;
      ofs_az <= '0;
      ofs_mx <= '0;
      ofs_my <= '0;
      ofs_mz <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACCEL_OFS_X: ofs_ax <= cfg_data;
        REG_ACCEL_OFS_Y: ofs_ay <= cfg_data;
        REG_ACCEL_OFS_Z: ofs_az <= cfg_data;
        REG_MAG_OFS_X:   ofs_mx <= cfg_data;
        REG_MAG_OFS_Y:   ofs_my <= cfg_data;
        REG_MAG_OFS_Z:   ofs_mz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full         = (count == (QPTR_W+1)'(QDEPTH));
  assign push         = fv && !full;
  assign sensor.ready = !fv || !full;
  assign take         = sensor.valid && sensor.ready;

  // remove offsets, flip accel y, z and mag z
  always_ff @(posedge clk) begin
    if (take) begin
      fword.ax <= XW'(sensor.accel_x) - XW'(ofs_ax);
      fword.ay <= XW'(ofs_ay) - XW'(sensor.accel_y);
      fword.az <= XW'(ofs_az) - XW'(sensor.accel_z);
      fword.mx <= XW'(sensor.mag_x) - XW'(ofs_mx);
      fword.my <= XW'(sensor.mag_y) - XW'(ofs_my);
      fword.mz <= XW'(ofs_mz) - XW'(sensor.mag_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) qmem[wr_ptr] <= fword;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end
  end

  assign q_valid = (count != '0);
  assign q_word  = qmem[rd_ptr];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count beyond depth");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push && !q_pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    fv && full |=> fv && $stable(fword))
    else $error("front word lost while queue full");
endmodule
`default_nettype wire

@@ rtl/tcc_back.sv @@
`default_nettype none
module tcc_back #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  tcc_pkg::axis_t q_word,
  tcc_out_if.source      attitude
);
  import tcc_pkg::*;

  localparam int T_ROOT = 2 + ROOT_BITS;
  localparam int T_ANG  = T_ROOT + N + 1;
  localparam int T_CLP  = T_ANG + 1;
  localparam int T_ROT  = T_CLP + N;
  localparam int T_HXY  = T_ROT + 4;
  localparam int T_TILT = T_HXY + N + 1;
  localparam int LAT    = T_TILT + 1;
  localparam int MW     = XW + CS_W;

  logic           en;
  logic [LAT-1:0] vld;

  // whole pipeline advances together; the last stage is the output register
  assign en    = !vld[LAT-1] || attitude.ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], q_valid};
  end

  // squares and sums for the roots
  logic signed [2*XW-1:0] sq_ax, sq_ay, sq_az;
  logic [2*XW-1:0]        sum_yz, sum_xz;
  logic [ROOT_BITS-1:0]   r_yz, r_xz;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ax  <= q_word.ax * q_word.ax;
      sq_ay  <= q_word.ay * q_word.ay;
      sq_az  <= q_word.az * q_word.az;
      sum_yz <= unsigned'(sq_ay) + unsigned'(sq_az);
      sum_xz <= unsigned'(sq_ax) + unsigned'(sq_az);
    end
  end

  tcc_isqrt u_root_yz (.clk(clk), .en(en), .sum(sum_yz), .root(r_yz));
  tcc_isqrt u_root_xz (.clk(clk), .en(en), .sum(sum_xz), .root(r_xz));

  logic [2*XW-1:0]      axy_d;
  logic signed [VW-1:0] ax_num, ay_num, rx_yz, rx_xz;

  tcc_dly #(.W(2*XW), .D(T_ROOT)) u_dly_axy (
    .clk(clk), .en(en), .d({q_word.ax, q_word.ay}), .q(axy_d));

  assign ax_num = VW'(signed'(axy_d[2*XW-1:XW])) <<< PRESHIFT;
  assign ay_num = VW'(signed'(axy_d[XW-1:0])) <<< PRESHIFT;
  assign rx_yz  = signed'({1'b0, r_yz});
  assign rx_xz  = signed'({1'b0, r_xz});

  logic signed [ANG_W-1:0] z_roll, z_pitch, roll_c, pitch_c;

  tcc_vec #(.IW(VW), .N(N)) u_roll (
    .clk(clk), .en(en), .y_in(ax_num), .x_in(rx_yz), .angle(z_roll));
  tcc_vec #(.IW(VW), .N(N)) u_pitch (
    .clk(clk), .en(en), .y_in(ay_num), .x_in(rx_xz), .angle(z_pitch));

  always_ff @(posedge clk) begin
    if (en) begin
      roll_c  <= clamp90(-z_roll);
      pitch_c <= clamp90(z_pitch);
    end
  end

  // raw heading straight from the queue head
  logic signed [VW-1:0]    mx_num, my_num;
  logic signed [ANG_W-1:0] z_raw;
  logic [ANG_W-1:0]        raw_d;

  assign mx_num = VW'(q_word.mx) <<< PRESHIFT;
  assign my_num = VW'(q_word.my) <<< PRESHIFT;

  tcc_vec #(.IW(VW), .N(N)) u_raw (
    .clk(clk), .en(en), .y_in(my_num), .x_in(mx_num), .angle(z_raw));
  tcc_dly #(.W(ANG_W), .D(T_TILT - N - 1)) u_dly_raw (
    .clk(clk), .en(en), .d(z_raw), .q(raw_d));

  // sine and cosine of roll and pitch
  logic signed [CS_W-1:0] cr, sr, cp, sp;

  tcc_rot #(.N(N)) u_rot_roll (
    .clk(clk), .en(en), .ang(roll_c), .cos_q30(cr), .sin_q30(sr));
  tcc_rot #(.N(N)) u_rot_pitch (
    .clk(clk), .en(en), .ang(pitch_c), .cos_q30(cp), .sin_q30(sp));

  logic [3*XW-1:0]      mag_d;
  logic signed [XW-1:0] mx_d, my_d, mz_d;

  tcc_dly #(.W(3*XW), .D(T_ROT)) u_dly_mag (
    .clk(clk), .en(en), .d({q_word.mx, q_word.my, q_word.mz}), .q(mag_d));

  assign mx_d = signed'(mag_d[3*XW-1:2*XW]);
  assign my_d = signed'(mag_d[2*XW-1:XW]);
  assign mz_d = signed'(mag_d[XW-1:0]);

  // tilt-compensated field, four stages
  logic signed [2*CS_W-1:0] p_spsr, p_crsp;
  logic signed [MW-1:0]     p_mycr, p_mzsr, p_mxcp, mxcp2, mxcp3, q_my, q_mz;
  logic signed [XW-1:0]     my1, mz1, my2, mz2;
  logic signed [CS_W-1:0]   spsr, crsp;
  logic signed [HW-1:0]     hy1, hy3, hy, hx;

  always_ff @(posedge clk) begin
    if (en) begin
      p_spsr <= sp * sr;
      p_crsp <= cr * sp;
      p_mycr <= my_d * cr;
      p_mzsr <= mz_d * sr;
      p_mxcp <= mx_d * cp;
      my1    <= my_d;
      mz1    <= mz_d;

      spsr   <= round_q30(p_spsr);
      crsp   <= round_q30(p_crsp);
      hy1    <= HW'(p_mycr) + HW'(p_mzsr);
      mxcp2  <= p_mxcp;
      my2    <= my1;
      mz2    <= mz1;

      q_my   <= my2 * spsr;
      q_mz   <= mz2 * crsp;
      hy3    <= hy1;
      mxcp3  <= mxcp2;

      hx     <= HW'(q_my) + HW'(mxcp3) - HW'(q_mz);
      hy     <= hy3;
    end
  end

  logic signed [ANG_W-1:0] z_tilt;

  tcc_vec #(.IW(HW), .N(N)) u_tilt (
    .clk(clk), .en(en), .y_in(hy), .x_in(hx), .angle(z_tilt));

  logic [2*ANG_W-1:0] rp_d;

  tcc_dly #(.W(2*ANG_W), .D(T_TILT - T_CLP)) u_dly_rp (
    .clk(clk), .en(en), .d({roll_c, pitch_c}), .q(rp_d));

  logic signed [ANG_W-1:0] roll_r, pitch_r;

  assign roll_r  = round_deg(signed'(rp_d[2*ANG_W-1:ANG_W]));
  assign pitch_r = round_deg(signed'(rp_d[ANG_W-1:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      attitude.roll_angle   <= roll_r[ROLL_W-1:0];
      attitude.pitch_angle  <= pitch_r[ROLL_W-1:0];
      attitude.heading_raw  <= wrap_heading(signed'(raw_d));
      attitude.heading_tilt <= wrap_heading(z_tilt);
    end
  end

  assign attitude.valid = vld[LAT-1];

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    attitude.valid |-> attitude.heading_raw < HEAD_W'(FULL_TURN) &&
                       attitude.heading_tilt < HEAD_W'(FULL_TURN))
    else $error("heading out of range");
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    attitude.valid |-> (attitude.roll_angle <= 15'sd11520) &&
                       (attitude.roll_angle >= -15'sd11520) &&
                       (attitude.pitch_angle <= 15'sd11520) &&
                       (attitude.pitch_angle >= -15'sd11520))
    else $error("roll or pitch beyond ninety degrees");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> vld[0])
    else $error("popped word not entered into pipeline");
endmodule
`default_nettype wire

@@ rtl/tilt_compensated_compass_unit.sv @@
`default_nettype none
// channel    dir  handshake      payload
// sensor     in   valid/ready    accel_x/y/z, mag_x/y/z (16b signed)
// attitude   out  valid/ready    roll_angle, pitch_angle (15b s), heading_raw/tilt (16b u)
// cfg        in   cfg_write      cfg_index (3b), cfg_data (16b), offsets 0..5
//
// One word per cycle is accepted while the attitude sink keeps taking results.
// Data passes through the input register, the queue, a 31-step root,
// then three chained CORDIC pipelines (angles, sin/cos, tilt heading).
// A stalled sink freezes the back pipeline; the queue keeps taking words until full.
// Reset clears offsets, queue and pipeline valids; no clearing pass.
module tilt_compensated_compass_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tcc_pkg::SAMPLE_W-1:0]  cfg_data,
  tcc_in_if.sink                        sensor,
  tcc_out_if.source                     attitude
);
  import tcc_pkg::*;

  logic  q_valid;
  logic  q_pop;
  axis_t q_word;

  tcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sensor    (sensor),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_word    (q_word)
  );

  tcc_back #(.N(CORDIC_STAGES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_word   (q_word),
    .attitude (attitude)
  );
endmodule
`default_nettype wire
